// File: rtl/core/qpm_pkg.sv
// shared widths, types and constants for the quaternion pose to matrix core
package qpm_pkg;

  localparam int QUAT_WIDTH  = 16;
  localparam int FRAC_BITS   = QUAT_WIDTH - 2;
  localparam int TRANS_WIDTH = 32;
  localparam int PROD_W      = 2 * QUAT_WIDTH;
  localparam int N2_W        = 2 * QUAT_WIDTH + 1;
  localparam int NUM_W       = 2 * QUAT_WIDTH + 2;
  localparam int QUO_W       = FRAC_BITS + 2;
  localparam int DIV_STAGES  = QUO_W;
  localparam int NUM_ENT     = 9;

  typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
  typedef logic signed [TRANS_WIDTH-1:0] trans_t;
  typedef logic        [N2_W-1:0]        mag_t;
  typedef logic        [QUO_W-1:0]       quo_t;

  // items that ride alongside the divider lanes
  typedef struct packed {
    logic               zero;
    logic [NUM_ENT-1:0] neg;
    trans_t             tx;
    trans_t             ty;
    trans_t             tz;
  } side_t;

endpackage

// File: rtl/core/qpm_divider.sv
// nine-lane restoring divider, one quotient bit per pipeline stage, shared divisor
module qpm_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_v,
  input  qpm_pkg::mag_t       den,
  input  qpm_pkg::mag_t       mag [qpm_pkg::NUM_ENT],
  input  qpm_pkg::side_t      side_in,
  output logic                out_v,
  output qpm_pkg::quo_t       quo [qpm_pkg::NUM_ENT],
  output qpm_pkg::side_t      side_out
);

  localparam int S = qpm_pkg::DIV_STAGES;
  localparam int L = qpm_pkg::NUM_ENT;
  localparam int W = qpm_pkg::N2_W;

  logic           v_s    [S+1];
  qpm_pkg::mag_t  d_s    [S+1];
  qpm_pkg::mag_t  rem_s  [S+1][L];
  qpm_pkg::quo_t  q_s    [S+1][L];
  qpm_pkg::side_t side_s [S+1];

  assign v_s[0]    = in_v;
  assign d_s[0]    = den;
  assign side_s[0] = side_in;
  always_comb begin
    for (int l = 0; l < L; l++) begin
      rem_s[0][l] = mag[l];
      q_s[0][l]   = '0;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [W:0]    rin  [L];
    logic [W:0]    diff [L];
    logic          bit_q[L];
    qpm_pkg::mag_t rnext[L];

    // first step takes the integer bit, later steps shift in a zero
    always_comb begin
      for (int l = 0; l < L; l++) begin
        rin[l]   = (k == 0) ? {1'b0, rem_s[k][l]} : {rem_s[k][l], 1'b0};
        diff[l]  = rin[l] - {1'b0, d_s[k]};
        bit_q[l] = (rin[l] >= {1'b0, d_s[k]});
        rnext[l] = bit_q[l] ? diff[l][W-1:0] : rin[l][W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_s[k+1]    <= d_s[k];
        side_s[k+1] <= side_s[k];
        for (int l = 0; l < L; l++) begin
          rem_s[k+1][l] <= rnext[l];
          q_s[k+1][l]   <= {q_s[k][l][qpm_pkg::QUO_W-2:0], bit_q[l]};
        end
      end
    end
  end

  assign out_v    = v_s[S];
  assign side_out = side_s[S];
  always_comb begin
    for (int l = 0; l < L; l++) quo[l] = q_s[S][l];
  end

endmodule

// File: rtl/core/quaternion_pose_to_matrix_core.sv
// top level: pipelined quaternion plus translation to homogeneous matrix columns
//
// One pose beat enters and one matrix beat leaves per clock while nothing holds the
// pipe. It has one multiply stage (ten 16x16 products), one sum stage (squared norm
// and the nine numerators), one magnitude stage, sixteen divider stages (one
// quotient bit each, nine lanes sharing the norm as divisor) and the output
// register that rounds ties away from zero, restores sign and saturates.
// A zero quaternion gives the identity rotation. Translation passes through.
// The whole pipe holds while a finished beat waits on out_stall.
module quaternion_pose_to_matrix_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qpm_pkg::quat_t  quat_x,
  input  qpm_pkg::quat_t  quat_y,
  input  qpm_pkg::quat_t  quat_z,
  input  qpm_pkg::quat_t  quat_w,
  input  qpm_pkg::trans_t trans_x,
  input  qpm_pkg::trans_t trans_y,
  input  qpm_pkg::trans_t trans_z,
  output logic           out_valid,
  input  logic           out_stall,
  output qpm_pkg::quat_t  rot_00,
  output qpm_pkg::quat_t  rot_01,
  output qpm_pkg::quat_t  rot_02,
  output qpm_pkg::quat_t  rot_10,
  output qpm_pkg::quat_t  rot_11,
  output qpm_pkg::quat_t  rot_12,
  output qpm_pkg::quat_t  rot_20,
  output qpm_pkg::quat_t  rot_21,
  output qpm_pkg::quat_t  rot_22,
  output qpm_pkg::trans_t col_x,
  output qpm_pkg::trans_t col_y,
  output qpm_pkg::trans_t col_z
);

  localparam int PW = qpm_pkg::PROD_W;
  localparam int NW = qpm_pkg::NUM_W;
  localparam int QW = qpm_pkg::QUAT_WIDTH;
  localparam int UW = qpm_pkg::QUO_W;
  localparam int L  = qpm_pkg::NUM_ENT;

  // global advance: only a waiting output beat holds the pipe
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: products
  logic signed [PW-1:0] p_xx, p_yy, p_zz, p_ww, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic                 v1;
  qpm_pkg::trans_t      t1x, t1y, t1z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_ww <= quat_w * quat_w;
      p_xy <= quat_x * quat_y;
      p_wz <= quat_w * quat_z;
      p_xz <= quat_x * quat_z;
      p_wy <= quat_w * quat_y;
      p_yz <= quat_y * quat_z;
      p_wx <= quat_w * quat_x;
      t1x  <= trans_x;
      t1y  <= trans_y;
      t1z  <= trans_z;
    end
  end

  // stage 2: squared norm and numerators
  logic signed [NW-1:0] e_xx, e_yy, e_zz, e_ww, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx, n2_c;
  assign e_xx = NW'(p_xx);
  assign e_yy = NW'(p_yy);
  assign e_zz = NW'(p_zz);
  assign e_ww = NW'(p_ww);
  assign e_xy = NW'(p_xy);
  assign e_wz = NW'(p_wz);
  assign e_xz = NW'(p_xz);
  assign e_wy = NW'(p_wy);
  assign e_yz = NW'(p_yz);
  assign e_wx = NW'(p_wx);
  assign n2_c = e_xx + e_yy + e_zz + e_ww;

  logic signed [NW-1:0] n2_r;
  logic signed [NW-1:0] num_r [L];
  logic                 v2;
  qpm_pkg::trans_t      t2x, t2y, t2z;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r     <= n2_c;
      num_r[0] <= n2_c - ((e_yy + e_zz) <<< 1);
      num_r[1] <= (e_xy - e_wz) <<< 1;
      num_r[2] <= (e_xz + e_wy) <<< 1;
      num_r[3] <= (e_xy + e_wz) <<< 1;
      num_r[4] <= n2_c - ((e_xx + e_zz) <<< 1);
      num_r[5] <= (e_yz - e_wx) <<< 1;
      num_r[6] <= (e_xz - e_wy) <<< 1;
      num_r[7] <= (e_yz + e_wx) <<< 1;
      num_r[8] <= n2_c - ((e_xx + e_yy) <<< 1);
      t2x      <= t1x;
      t2y      <= t1y;
      t2z      <= t1z;
    end
  end

  // stage 3: magnitudes, signs, zero-norm flag
  logic            v3;
  qpm_pkg::mag_t   den3;
  qpm_pkg::mag_t   mag3 [L];
  qpm_pkg::side_t  side3;
  logic [NW-1:0]   absn [L];

  always_comb begin
    for (int l = 0; l < L; l++) absn[l] = num_r[l][NW-1] ? -num_r[l] : num_r[l];
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3       <= n2_r[qpm_pkg::N2_W-1:0];
      side3.zero <= (n2_r == '0);
      side3.tx   <= t2x;
      side3.ty   <= t2y;
      side3.tz   <= t2z;
      for (int l = 0; l < L; l++) begin
        mag3[l]      <= absn[l][qpm_pkg::N2_W-1:0];
        side3.neg[l] <= num_r[l][NW-1];
      end
    end
  end

  // divider lanes
  logic           vd;
  qpm_pkg::quo_t  quo [L];
  qpm_pkg::side_t sided;

  qpm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (v3),
    .den      (den3),
    .mag      (mag3),
    .side_in  (side3),
    .out_v    (vd),
    .quo      (quo),
    .side_out (sided)
  );

  // output stage: round half away, sign, saturate, identity on zero norm
  logic [UW:0]          rnd  [L];
  logic signed [UW+1:0] sres [L];
  qpm_pkg::quat_t       ent  [L];

  localparam logic signed [UW+1:0] SAT_HI = (UW+2)'((1 <<< (QW-1)) - 1);
  localparam logic signed [UW+1:0] SAT_LO = -(UW+2)'(1 <<< (QW-1));
  localparam qpm_pkg::quat_t ONE = QW'(1 <<< qpm_pkg::FRAC_BITS);

  always_comb begin
    for (int l = 0; l < L; l++) begin
      rnd[l]  = ({1'b0, quo[l]} + (UW+1)'(1)) >> 1;
      sres[l] = sided.neg[l] ? -$signed({1'b0, rnd[l]}) : $signed({1'b0, rnd[l]});
      if (sided.zero) ent[l] = (l % 4 == 0) ? ONE : '0;
      else if (sres[l] > SAT_HI) ent[l] = SAT_HI[QW-1:0];
      else if (sres[l] < SAT_LO) ent[l] = SAT_LO[QW-1:0];
      else ent[l] = sres[l][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_00 <= ent[0];
      rot_01 <= ent[1];
      rot_02 <= ent[2];
      rot_10 <= ent[3];
      rot_11 <= ent[4];
      rot_12 <= ent[5];
      rot_20 <= ent[6];
      rot_21 <= ent[7];
      rot_22 <= ent[8];
      col_x  <= sided.tx;
      col_y  <= sided.ty;
      col_z  <= sided.tz;
    end
  end

endmodule

// File: sim/testbench.sv
// self-checking testbench for the quaternion pose to matrix core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 1100;
  localparam int LATENCY     = 20;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PAUSE_AT    = 500;

  // one pose beat going in
  typedef struct {
    qpm_pkg::quat_t  qx, qy, qz, qw;
    qpm_pkg::trans_t tx, ty, tz;
  } pose_t;

  // one matrix beat coming out
  typedef struct {
    qpm_pkg::quat_t  rot [9];
    qpm_pkg::trans_t cx, cy, cz;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  qpm_pkg::quat_t  quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  qpm_pkg::trans_t trans_x = '0, trans_y = '0, trans_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  qpm_pkg::quat_t  rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22;
  qpm_pkg::trans_t col_x, col_y, col_z;

  pose_t   pose_queue [$];
  matrix_t matrix_queue [$];
  int      errors = 0;
  int      poses_sent = 0;
  int      matrices_seen = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0;

  quaternion_pose_to_matrix_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // round(num * 2^FRAC_BITS / den), ties away from zero, saturated
  function automatic qpm_pkg::quat_t rot_entry(longint num, longint den);
    longint mag, q, r, val;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    r = mag % den;
    for (int i = 0; i < qpm_pkg::FRAC_BITS + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    q = (q + 1) >>> 1;
    val = (num < 0) ? -q : q;
    if (val > (2 ** (qpm_pkg::QUAT_WIDTH - 1)) - 1) val = (2 ** (qpm_pkg::QUAT_WIDTH - 1)) - 1;
    if (val < -(2 ** (qpm_pkg::QUAT_WIDTH - 1))) val = -(2 ** (qpm_pkg::QUAT_WIDTH - 1));
    return qpm_pkg::quat_t'(val);
  endfunction

  function automatic matrix_t pose_matrix(pose_t p);
    matrix_t m;
    longint x, y, z, w, xx, yy, zz, n2;
    longint nums [9];
    x = p.qx; y = p.qy; z = p.qz; w = p.qw;
    xx = x * x; yy = y * y; zz = z * z;
    n2 = xx + yy + zz + w * w;
    nums[0] = n2 - 2 * (yy + zz);
    nums[1] = 2 * (x * y - w * z);
    nums[2] = 2 * (x * z + w * y);
    nums[3] = 2 * (x * y + w * z);
    nums[4] = n2 - 2 * (xx + zz);
    nums[5] = 2 * (y * z - w * x);
    nums[6] = 2 * (x * z - w * y);
    nums[7] = 2 * (y * z + w * x);
    nums[8] = n2 - 2 * (xx + yy);
    for (int i = 0; i < 9; i++) begin
      // zero quaternion falls back to the identity
      if (n2 == 0) m.rot[i] = (i % 4 == 0) ? qpm_pkg::quat_t'(1 << qpm_pkg::FRAC_BITS) : '0;
      else m.rot[i] = rot_entry(nums[i], n2);
    end
    m.cx = p.tx; m.cy = p.ty; m.cz = p.tz;
    return m;
  endfunction

  function automatic qpm_pkg::quat_t rand_quat();
    // half the time full range, otherwise within unit magnitude or tiny components
    case ($urandom_range(3))
      0: return qpm_pkg::quat_t'($urandom_range(65535));
      1: return qpm_pkg::quat_t'($signed($urandom_range(32768)) - 16384);
      2: return qpm_pkg::quat_t'($signed($urandom_range(8)) - 4);
      default: return qpm_pkg::quat_t'($urandom);
    endcase
  endfunction

  task automatic add_pose(qpm_pkg::quat_t qx, qpm_pkg::quat_t qy, qpm_pkg::quat_t qz,
                          qpm_pkg::quat_t qw, qpm_pkg::trans_t tx, qpm_pkg::trans_t ty,
                          qpm_pkg::trans_t tz);
    pose_t p;
    p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
    p.tx = tx; p.ty = ty; p.tz = tz;
    pose_queue = {pose_queue, p};
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on matrix beat %0d: %s got %0d expected %0d",
             matrices_seen, field, got, want);
    errors++;
  endtask

  initial begin
    qpm_pkg::quat_t mx, mn;
    mx = qpm_pkg::quat_t'(16'h7fff);
    mn = qpm_pkg::quat_t'(16'h8000);
    // directed: zero quaternion, unit axes, extremes, mixed signs
    add_pose(0, 0, 0, 0, 0, 0, 0);
    add_pose(0, 0, 0, 16384, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    add_pose(16384, 0, 0, 0, 1, -1, 0);
    add_pose(0, 16384, 0, 0, 0, 0, 0);
    add_pose(0, 0, 16384, 0, 0, 0, 0);
    add_pose(mx, mx, mx, mx, 32'h80000000, 32'h7fffffff, 32'h55555555);
    add_pose(mn, mn, mn, mn, 32'haaaaaaaa, 0, 0);
    add_pose(mn, mx, mn, mx, 0, 0, 0);
    add_pose(mx, 0, 0, 0, 0, 0, 0);
    add_pose(mn, 0, 0, 0, 0, 0, 0);
    add_pose(0, 0, 0, mn, 0, 0, 0);
    add_pose(1, 0, 0, 0, 0, 0, 0);
    add_pose(0, -1, 0, 0, 0, 0, 0);
    add_pose(1, 1, 1, 1, 0, 0, 0);
    add_pose(-1, 1, -1, 1, 0, 0, 0);
    add_pose(11585, 0, 0, 11585, 0, 0, 0);
    add_pose(8192, 8192, 8192, 8192, 0, 0, 0);
    add_pose(-8192, 8192, -8192, -8192, 0, 0, 0);
    add_pose(3, 0, 0, 1, 0, 0, 0);
    add_pose(qpm_pkg::quat_t'(16'h5555), qpm_pkg::quat_t'(16'haaaa),
             qpm_pkg::quat_t'(16'h5555), qpm_pkg::quat_t'(16'haaaa), 0, 0, 0);
    for (int i = 0; i < N_RANDOM; i++)
      add_pose(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
               qpm_pkg::trans_t'($urandom), qpm_pkg::trans_t'($urandom),
               qpm_pkg::trans_t'($urandom));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: bursts and gaps, plus one drain pause midway
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) poses_sent <= poses_sent + 1;
      if (in_valid && in_stall) begin
        // beat stalled, payload stays put
      end else if (hold_off) begin
        in_valid <= 1'b0;
        if (matrix_queue.size() == 0) hold_off <= 1'b0;
      end else if (poses_sent == PAUSE_AT - 1 && in_valid) begin
        in_valid <= 1'b0;
        hold_off <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pose_queue.size() == 0) begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end else begin
        pose_t p;
        p = pose_queue.pop_front();
        in_valid <= 1'b1;
        quat_x <= p.qx; quat_y <= p.qy; quat_z <= p.qz; quat_w <= p.qw;
        trans_x <= p.tx; trans_y <= p.ty; trans_z <= p.tz;
        matrix_queue = {matrix_queue, pose_matrix(p)};
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(40);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end
    end
  end

  // receiver stall pattern: open stretches mixed with random stalling
  always @(posedge clk) begin
    int phase;
    phase = (matrices_seen / 128) % 3;
    if (phase == 0) out_stall <= 1'b0;
    else if (phase == 1) out_stall <= ($urandom_range(3) == 0);
    else out_stall <= ($urandom_range(1) == 0);
  end

  // monitor: compare each matrix beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      qpm_pkg::quat_t got [9];
      matrix_t m;
      got = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
      if (matrix_queue.size() == 0) begin
        $display("matrix beat %0d arrived with nothing predicted", matrices_seen);
        errors++;
      end else begin
        m = matrix_queue.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== m.rot[i])
            report_mismatch($sformatf("rot_%0d%0d", i / 3, i % 3), got[i], m.rot[i]);
        if (col_x !== m.cx) report_mismatch("col_x", col_x, m.cx);
        if (col_y !== m.cy) report_mismatch("col_y", col_y, m.cy);
        if (col_z !== m.cz) report_mismatch("col_z", col_z, m.cz);
      end
      matrices_seen <= matrices_seen + 1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    wait (stim_done && matrix_queue.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d pose beats and %0d matrix beats, incl. zero and extreme",
             poses_sent, matrices_seen);
    $display("quaternions, one drain pause and bursty stalls on both sides");
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

// File: quaternion_pose_to_matrix_core.f
rtl/core/qpm_pkg.sv
rtl/core/qpm_divider.sv
rtl/core/quaternion_pose_to_matrix_core.sv
sim/testbench.sv
